FILE: rtl/ufp_pkg.sv
// shared types, register codes and reset values for the frame parser
`default_nettype none

package ufp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_START_FIRST   = 3'd0;
    localparam logic [IDX_W-1:0] REG_START_SECOND  = 3'd1;
    localparam logic [IDX_W-1:0] REG_TRAILER_VALUE = 3'd2;
    localparam logic [IDX_W-1:0] REG_MAX_PAYLOAD   = 3'd3;
    localparam logic [IDX_W-1:0] REG_LEFT_TYPE     = 3'd4;
    localparam logic [IDX_W-1:0] REG_RIGHT_TYPE    = 3'd5;

    localparam logic [BYTE_W-1:0] RST_START_FIRST   = 8'h55;
    localparam logic [BYTE_W-1:0] RST_START_SECOND  = 8'hAA;
    localparam logic [BYTE_W-1:0] RST_TRAILER_VALUE = 8'h45;
    localparam logic [BYTE_W-1:0] RST_MAX_PAYLOAD   = 8'd23;
    localparam logic [BYTE_W-1:0] RST_LEFT_TYPE     = 8'd2;
    localparam logic [BYTE_W-1:0] RST_RIGHT_TYPE    = 8'd3;

    localparam logic [BYTE_W-1:0] SECOND_MASK = 8'hFE;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SECOND  = 3'd1,
        PH_TYPE    = 3'd2,
        PH_LENGTH  = 3'd3,
        PH_DATA    = 3'd4,
        PH_TRAILER = 3'd5
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] start_first;
        logic [BYTE_W-1:0] start_second;
        logic [BYTE_W-1:0] trailer_value;
        logic [BYTE_W-1:0] max_payload;
        logic [BYTE_W-1:0] left_type;
        logic [BYTE_W-1:0] right_type;
    } cfg_t;

    typedef struct packed {
        logic              header_error;
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_end;
        logic              frame_good;
        logic [BYTE_W-1:0] frame_type;
        logic              relay_left;
        logic              relay_right;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/uart_frame_parser_relay_toggle.sv
// frame parser with two toggle relays: top level
//
// input channel: one received serial byte per request on rx_byte, taken at a
// clock edge where in_valid is high and in_stall is low.
// output channel: exactly one result per input byte, in order, on the result
// ports, taken at an edge where out_valid is high and out_stall is low.
// configuration: cfg_we writes cfg_data into register cfg_index at the edge;
// indexes beyond the register list are ignored. write only while idle.
// data path: a byte taken at an edge sits in the input register until the
// parser takes it, and its result is then loaded into the output register,
// from which it shows on the result ports.
// throughput: one byte per cycle while the receiver is not stalling; the frame
// state update between the input and result registers is combinational.
// stall: while out_stall holds a result, the input register keeps its byte
// and in_stall rises once that register is full; nothing is lost or repeated.
// reset: hunting for the first start byte, both relays off, registers at
// their default values, both channels empty.
`default_nettype none

module uart_frame_parser_relay_toggle (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [ufp_pkg::BYTE_W-1:0]  rx_byte,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             header_error,
    output logic                             payload_valid,
    output logic [ufp_pkg::BYTE_W-1:0]       payload_byte,
    output logic                             frame_end,
    output logic                             frame_good,
    output logic [ufp_pkg::BYTE_W-1:0]       frame_type,
    output logic                             relay_left,
    output logic                             relay_right,
    input  wire logic                        cfg_we,
    input  wire logic [ufp_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [ufp_pkg::BYTE_W-1:0]  cfg_data
);

    ufp_pkg::cfg_t              cfg;
    ufp_pkg::result_t           res;
    logic                       s_valid;
    logic [ufp_pkg::BYTE_W-1:0] s_byte;
    logic                       take;

    ufp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ufp_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .take     (take),
        .s_valid  (s_valid),
        .s_byte   (s_byte)
    );

    ufp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_byte    (s_byte),
        .take      (take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign header_error  = res.header_error;
    assign payload_valid = res.payload_valid;
    assign payload_byte  = res.payload_byte;
    assign frame_end     = res.frame_end;
    assign frame_good    = res.frame_good;
    assign frame_type    = res.frame_type;
    assign relay_left    = res.relay_left;
    assign relay_right   = res.relay_right;

endmodule

`default_nettype wire

FILE: rtl/ufp_cfg_regs.sv
// configuration register bank with plain write port
`default_nettype none

module ufp_cfg_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [ufp_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [ufp_pkg::BYTE_W-1:0]  cfg_data,
    output ufp_pkg::cfg_t                    cfg
);

    ufp_pkg::cfg_t cfg_reg;
    ufp_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ufp_pkg::REG_START_FIRST:   cfg_next.start_first   = cfg_data;
                ufp_pkg::REG_START_SECOND:  cfg_next.start_second  = cfg_data;
                ufp_pkg::REG_TRAILER_VALUE: cfg_next.trailer_value = cfg_data;
                ufp_pkg::REG_MAX_PAYLOAD:   cfg_next.max_payload   = cfg_data;
                ufp_pkg::REG_LEFT_TYPE:     cfg_next.left_type     = cfg_data;
                ufp_pkg::REG_RIGHT_TYPE:    cfg_next.right_type    = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_first   <= ufp_pkg::RST_START_FIRST;
            cfg_reg.start_second  <= ufp_pkg::RST_START_SECOND;
            cfg_reg.trailer_value <= ufp_pkg::RST_TRAILER_VALUE;
            cfg_reg.max_payload   <= ufp_pkg::RST_MAX_PAYLOAD;
            cfg_reg.left_type     <= ufp_pkg::RST_LEFT_TYPE;
            cfg_reg.right_type    <= ufp_pkg::RST_RIGHT_TYPE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/ufp_in_stage.sv
// input register stage for received bytes
`default_nettype none

module ufp_in_stage (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [ufp_pkg::BYTE_W-1:0]  rx_byte,
    input  wire logic                        take,
    output logic                             s_valid,
    output logic [ufp_pkg::BYTE_W-1:0]       s_byte
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [ufp_pkg::BYTE_W-1:0] byte_reg;
    logic                       load;

    // stage may refill whenever it is empty or its request moves on
    assign in_stall   = valid_reg && !take;
    assign load       = in_valid && !in_stall;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign s_valid = valid_reg;
    assign s_byte  = byte_reg;

endmodule

`default_nettype wire

FILE: rtl/ufp_parser.sv
// frame state machine, relay levels and result register
`default_nettype none

module ufp_parser (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ufp_pkg::cfg_t               cfg,
    input  wire logic                        s_valid,
    input  wire logic [ufp_pkg::BYTE_W-1:0]  s_byte,
    output logic                             take,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output ufp_pkg::result_t                 res
);

    ufp_pkg::phase_t            phase_reg;
    ufp_pkg::phase_t            phase_next;
    logic [ufp_pkg::BYTE_W-1:0] count_reg;
    logic [ufp_pkg::BYTE_W-1:0] count_next;
    logic [ufp_pkg::BYTE_W-1:0] count_inc;
    logic [ufp_pkg::BYTE_W-1:0] second_reg;
    logic [ufp_pkg::BYTE_W-1:0] second_next;
    logic [ufp_pkg::BYTE_W-1:0] type_reg;
    logic [ufp_pkg::BYTE_W-1:0] type_next;
    logic [ufp_pkg::BYTE_W-1:0] length_reg;
    logic [ufp_pkg::BYTE_W-1:0] length_next;
    logic                       left_reg;
    logic                       left_next;
    logic                       right_reg;
    logic                       right_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    ufp_pkg::result_t           res_reg;
    ufp_pkg::result_t           res_next;
    logic                       out_free;
    logic                       header_bad;

    assign out_free       = !out_valid_reg || !out_stall;
    assign take           = s_valid && out_free;
    assign out_valid_next = take ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    assign count_inc      = count_reg + 8'd1;
    assign header_bad     = ((second_reg & ufp_pkg::SECOND_MASK)
                             != (cfg.start_second & ufp_pkg::SECOND_MASK))
                            || (s_byte > cfg.max_payload);

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        second_next = second_reg;
        type_next   = type_reg;
        length_next = length_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        res_next    = '0;

        case (phase_reg)
            ufp_pkg::PH_SECOND:
            begin
                second_next = s_byte;
                phase_next  = ufp_pkg::PH_TYPE;
            end
            ufp_pkg::PH_TYPE:
            begin
                type_next  = s_byte;
                phase_next = ufp_pkg::PH_LENGTH;
            end
            ufp_pkg::PH_LENGTH:
            begin
                length_next = s_byte;
                if (header_bad)
                begin
                    res_next.header_error = 1'b1;
                    phase_next            = ufp_pkg::PH_HUNT;
                end
                else if (s_byte == '0)
                begin
                    phase_next = ufp_pkg::PH_TRAILER;
                end
                else
                begin
                    count_next = '0;
                    phase_next = ufp_pkg::PH_DATA;
                end
            end
            ufp_pkg::PH_DATA:
            begin
                res_next.payload_valid = 1'b1;
                res_next.payload_byte  = s_byte;
                count_next             = count_inc;
                if (count_inc == length_reg)
                begin
                    phase_next = ufp_pkg::PH_TRAILER;
                end
            end
            ufp_pkg::PH_TRAILER:
            begin
                res_next.frame_end  = 1'b1;
                res_next.frame_type = type_reg;
                if (s_byte == cfg.trailer_value)
                begin
                    res_next.frame_good = 1'b1;
                    if (type_reg == cfg.left_type)
                    begin
                        left_next = !left_reg;
                    end
                    if (type_reg == cfg.right_type)
                    begin
                        right_next = !right_reg;
                    end
                end
                phase_next = ufp_pkg::PH_HUNT;
            end
            default:
            begin
                // unused codes hunt as well
                if (s_byte == cfg.start_first)
                begin
                    phase_next = ufp_pkg::PH_SECOND;
                end
                else
                begin
                    phase_next = ufp_pkg::PH_HUNT;
                end
            end
        endcase

        res_next.relay_left  = left_next;
        res_next.relay_right = right_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ufp_pkg::PH_HUNT;
            count_reg     <= '0;
            second_reg    <= '0;
            type_reg      <= '0;
            length_reg    <= '0;
            left_reg      <= 1'b0;
            right_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                second_reg <= second_next;
                type_reg   <= type_next;
                length_reg <= length_next;
                left_reg   <= left_next;
                right_reg  <= right_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

`ifndef NO_ASSERTIONS
    a_data_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == ufp_pkg::PH_DATA |-> length_reg != '0 && count_reg < length_reg)
        else $error("payload count outside frame length");

    a_left_on_good: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(left_reg) |-> out_valid_reg && res_reg.frame_good)
        else $error("left relay moved without a good frame");

    a_right_on_good: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(right_reg) |-> out_valid_reg && res_reg.frame_good)
        else $error("right relay moved without a good frame");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0({res_reg.header_error, res_reg.payload_valid,
                                    res_reg.frame_end}))
        else $error("result marks more than one kind of byte");

    a_relay_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> res_reg.relay_left == left_reg
                          && res_reg.relay_right == right_reg)
        else $error("shown relay level differs from held level");
`endif

endmodule

`default_nettype wire

FILE: tb/uart_frame_parser_relay_toggle_tb.sv
`timescale 1ns / 100ps
// self-checking bench for the frame parser: directed frames, then random frame streams under several register settings and flow-control mixes

module uart_frame_parser_relay_toggle_tb;

    import ufp_pkg::*;

    localparam int unsigned      CYCLE_LIMIT  = 400_000;
    localparam int unsigned      ROUNDS       = 8;
    localparam int unsigned      ROUND_BYTES  = 235;
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam cfg_t DEFAULT_REGS = '{RST_START_FIRST, RST_START_SECOND, RST_TRAILER_VALUE,
                                      RST_MAX_PAYLOAD, RST_LEFT_TYPE, RST_RIGHT_TYPE};
    localparam cfg_t LOW_REGS     = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
    localparam cfg_t HIGH_REGS    = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h80};

    typedef enum int {
        SHAPE_GOOD,
        SHAPE_BAD_SECOND,
        SHAPE_TOO_LONG,
        SHAPE_BAD_TRAILER,
        SHAPE_CUT,
        SHAPE_NOISE
    } frame_shape_t;

    class relay_frame_tracker;
        cfg_t              regs;
        phase_t            phase;
        logic [BYTE_W-1:0] held_second;
        logic [BYTE_W-1:0] held_type;
        logic [BYTE_W-1:0] held_length;
        logic [BYTE_W-1:0] data_count;
        logic              left_on;
        logic              right_on;
        result_t           owed_results[$];
        int unsigned       errors;
        int unsigned       checked;
        int unsigned       toggles;

        function new();
            regs        = DEFAULT_REGS;
            phase       = PH_HUNT;
            held_second = '0;
            held_type   = '0;
            held_length = '0;
            data_count  = '0;
            left_on     = 1'b0;
            right_on    = 1'b0;
            errors      = 0;
            checked     = 0;
            toggles     = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
            case (idx)
                REG_START_FIRST:   regs.start_first   = val;
                REG_START_SECOND:  regs.start_second  = val;
                REG_TRAILER_VALUE: regs.trailer_value = val;
                REG_MAX_PAYLOAD:   regs.max_payload   = val;
                REG_LEFT_TYPE:     regs.left_type     = val;
                REG_RIGHT_TYPE:    regs.right_type    = val;
                default: ;
            endcase
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b);
            result_t r;
            r = '0;
            case (phase)
                PH_SECOND:
                begin
                    held_second = b;
                    phase       = PH_TYPE;
                end
                PH_TYPE:
                begin
                    held_type = b;
                    phase     = PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    held_length = b;
                    if ((held_second & SECOND_MASK) != (regs.start_second & SECOND_MASK)
                        || b > regs.max_payload)
                    begin
                        r.header_error = 1'b1;
                        phase          = PH_HUNT;
                    end
                    else if (b == '0)
                    begin
                        phase = PH_TRAILER;
                    end
                    else
                    begin
                        data_count = '0;
                        phase      = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b;
                    data_count      = data_count + 1'b1;
                    if (data_count == held_length)
                        phase = PH_TRAILER;
                end
                PH_TRAILER:
                begin
                    r.frame_end  = 1'b1;
                    r.frame_type = held_type;
                    if (b == regs.trailer_value)
                    begin
                        r.frame_good = 1'b1;
                        if (held_type == regs.left_type)
                        begin
                            left_on = !left_on;
                            toggles++;
                        end
                        if (held_type == regs.right_type)
                        begin
                            right_on = !right_on;
                            toggles++;
                        end
                    end
                    phase = PH_HUNT;
                end
                default:
                begin
                    phase = (b == regs.start_first) ? PH_SECOND : PH_HUNT;
                end
            endcase
            r.relay_left  = left_on;
            r.relay_right = right_on;
            owed_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [BYTE_W-1:0] want,
                                    logic [BYTE_W-1:0] got);
            if (want !== got)
            begin
                $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (owed_results.size() == 0)
            begin
                $error("result arrived with no request outstanding");
                errors++;
                return;
            end
            want = owed_results.pop_front();
            checked++;
            compare_field("header_error", want.header_error, got.header_error);
            compare_field("payload_valid", want.payload_valid, got.payload_valid);
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("frame_end", want.frame_end, got.frame_end);
            compare_field("frame_good", want.frame_good, got.frame_good);
            compare_field("frame_type", want.frame_type, got.frame_type);
            compare_field("relay_left", want.relay_left, got.relay_left);
            compare_field("relay_right", want.relay_right, got.relay_right);
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [BYTE_W-1:0] rx_byte;
    logic              out_valid;
    logic              out_stall;
    logic              header_error;
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_end;
    logic              frame_good;
    logic [BYTE_W-1:0] frame_type;
    logic              relay_left;
    logic              relay_right;
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_index;
    logic [BYTE_W-1:0] cfg_data;

    result_t           seen;
    int unsigned       cycles = 0;
    int unsigned       sender_pct = 0;
    int unsigned       stall_pct = 0;
    int unsigned       frame_bytes = 0;
    int unsigned       frames_sent = 0;
    int unsigned       settings_used = 0;

    relay_frame_tracker tracker = new();

    uart_frame_parser_relay_toggle dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .header_error  (header_error),
        .payload_valid (payload_valid),
        .payload_byte  (payload_byte),
        .frame_end     (frame_end),
        .frame_good    (frame_good),
        .frame_type    (frame_type),
        .relay_left    (relay_left),
        .relay_right   (relay_right),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    assign seen = {header_error, payload_valid, payload_byte, frame_end, frame_good,
                   frame_type, relay_left, relay_right};

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(seen);
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        @(negedge clk);
        while ($urandom_range(99) < sender_pct)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_byte(b);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        tracker.set_reg(idx, val);
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(input cfg_t s);
        put_reg(REG_START_FIRST, s.start_first);
        put_reg(REG_START_SECOND, s.start_second);
        put_reg(REG_TRAILER_VALUE, s.trailer_value);
        put_reg(REG_MAX_PAYLOAD, s.max_payload);
        put_reg(REG_LEFT_TYPE, s.left_type);
        put_reg(REG_RIGHT_TYPE, s.right_type);
        // writes past the register list must leave everything alone
        put_reg(REG_SPARE_LO, 8'($urandom));
        put_reg(REG_SPARE_HI, 8'($urandom));
        end_writes();
        settings_used++;
    endtask

    task automatic send_frame(input frame_shape_t shape, input logic [BYTE_W-1:0] kind,
                              input int unsigned len);
        logic [BYTE_W-1:0] seq[$];
        logic [BYTE_W-1:0] second;
        logic [BYTE_W-1:0] trailer;
        int unsigned       count;
        second  = tracker.regs.start_second ^ 8'($urandom_range(1));
        trailer = tracker.regs.trailer_value;
        if (shape == SHAPE_BAD_SECOND)
            second = tracker.regs.start_second ^ {7'($urandom_range(1, 127)), 1'b0};
        if (shape == SHAPE_BAD_TRAILER)
            trailer = trailer ^ 8'($urandom_range(1, 255));
        seq.push_back(tracker.regs.start_first);
        seq.push_back(second);
        seq.push_back(kind);
        seq.push_back(8'(len));
        if (shape != SHAPE_BAD_SECOND && shape != SHAPE_TOO_LONG)
        begin
            repeat (len) seq.push_back(8'($urandom));
            seq.push_back(trailer);
        end
        count = (shape == SHAPE_CUT) ? $urandom_range(1, seq.size() - 1) : seq.size();
        for (int i = 0; i < count; i++)
            send_byte(seq[i]);
        frame_bytes += count;
        frames_sent++;
    endtask

    task automatic random_frames(input int unsigned quota);
        int unsigned       goal;
        int unsigned       roll;
        int unsigned       len;
        int unsigned       top;
        frame_shape_t      shape;
        logic [BYTE_W-1:0] kind;
        goal = frame_bytes + quota;
        while (frame_bytes < goal)
        begin
            roll  = $urandom_range(99);
            shape = (roll < 60) ? SHAPE_GOOD :
                    (roll < 70) ? SHAPE_BAD_TRAILER :
                    (roll < 78) ? SHAPE_BAD_SECOND :
                    (roll < 86) ? SHAPE_TOO_LONG :
                    (roll < 93) ? SHAPE_CUT : SHAPE_NOISE;
            top = tracker.regs.max_payload;
            // mostly short frames, now and then up to the limit
            len = ($urandom_range(19) == 0) ? $urandom_range(0, top)
                                            : $urandom_range(0, (top < 6) ? top : 6);
            if (shape == SHAPE_TOO_LONG)
            begin
                if (top == 255)
                    shape = SHAPE_BAD_SECOND;
                else
                    len = $urandom_range(top + 1, 255);
            end
            roll = $urandom_range(9);
            kind = (roll < 4) ? tracker.regs.left_type :
                   (roll < 8) ? tracker.regs.right_type : 8'($urandom);
            if (shape == SHAPE_NOISE)
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            else
                send_frame(shape, kind, len);
        end
    endtask

    initial
    begin
        cfg_t s;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        out_stall = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int round = 0; round < ROUNDS; round++)
        begin
            case (round % 4)
                0:       begin sender_pct = 0;  stall_pct = 0;  end
                1:       begin sender_pct = 64; stall_pct = 0;  end
                2:       begin sender_pct = 0;  stall_pct = 64; end
                default: begin sender_pct = 30; stall_pct = 30; end
            endcase

            if (round == 0)
            begin
                // ignored while hunting
                send_byte(8'hFF);
                send_byte(8'h00);
                // left frame, one payload byte
                send_byte(RST_START_FIRST);
                send_byte(RST_START_SECOND);
                send_byte(RST_LEFT_TYPE);
                send_byte(8'd1);
                send_byte(8'hFF);
                send_byte(RST_TRAILER_VALUE);
                // right frame, empty payload, low bit of second start set
                send_byte(RST_START_FIRST);
                send_byte(RST_START_SECOND | 8'h01);
                send_byte(RST_RIGHT_TYPE);
                send_byte(8'd0);
                send_byte(RST_TRAILER_VALUE);
                // length one past the limit
                send_byte(RST_START_FIRST);
                send_byte(RST_START_SECOND);
                send_byte(RST_LEFT_TYPE);
                send_byte(RST_MAX_PAYLOAD + 8'd1);
                // wrong second start
                send_byte(RST_START_FIRST);
                send_byte(RST_START_SECOND ^ 8'h02);
                send_byte(RST_LEFT_TYPE);
                send_byte(8'd0);
                // start register changes mid-frame, then a bad trailer
                send_byte(RST_START_FIRST);
                settle();
                put_reg(REG_START_FIRST, 8'h00);
                end_writes();
                send_byte(RST_START_SECOND);
                send_byte(RST_RIGHT_TYPE);
                send_byte(8'd0);
                send_byte(RST_TRAILER_VALUE ^ 8'h45);
                settle();
                apply_settings(DEFAULT_REGS);
            end
            else if (round == 1)
            begin
                apply_settings(LOW_REGS);
            end
            else if (round == 2)
            begin
                apply_settings(HIGH_REGS);
            end
            else
            begin
                s.start_first   = 8'($urandom);
                s.start_second  = 8'($urandom);
                s.trailer_value = 8'($urandom);
                s.max_payload   = 8'($urandom_range(0, 30));
                s.left_type     = 8'($urandom);
                s.right_type    = (round == 5) ? s.left_type : 8'($urandom);
                apply_settings(s);
            end

            random_frames(ROUND_BYTES);
            settle();
        end

        $display("sent %0d frames (%0d framed bytes) across %0d register settings",
                 frames_sent, frame_bytes, settings_used);
        $display("checked %0d results, %0d relay toggles predicted, four flow-control mixes",
                 tracker.checked, tracker.toggles);
        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
